// ===== src/vrt_pkg.sv =====
`default_nettype none

package vrt_pkg;

    // Longest record that the byte counter is sized for.
    localparam int MAX_RECORD_BYTES = 65536;

    // Byte position and every offset saturate at this value.
    localparam logic [15:0] POS_CEIL = (MAX_RECORD_BYTES - 1 < 65535) ?
        16'(MAX_RECORD_BYTES - 1) : 16'hFFFF;

    // Separator characters.
    localparam logic [7:0] TAB_CH   = 8'h09;
    localparam logic [7:0] SEMI_CH  = 8'h3B;
    localparam logic [7:0] COLON_CH = 8'h3A;

    // Field counts and the field numbers whose start offsets are recorded.
    localparam logic [15:0] FIELDS_NO_SAMPLES = 16'd8;
    localparam logic [15:0] FIELDS_FIXED      = 16'd9;
    localparam logic [15:0] FIELD_MAX         = 16'hFFFF;
    localparam logic [15:0] FLD_POS           = 16'd2;
    localparam logic [15:0] FLD_REF           = 16'd4;
    localparam logic [15:0] FLD_QUAL          = 16'd6;
    localparam logic [15:0] FLD_INFO          = 16'd8;
    localparam logic [15:0] FLD_FORMAT        = 16'd9;
    localparam logic [15:0] FLD_SAMPLE        = 16'd10;

    // Contents of the input register.
    typedef struct packed {
        logic       valid;
        logic [7:0] in_byte;
        logic       in_last;
    } vrt_stage_t;

    // One result item.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        logic [15:0] pos_offset;
        logic [15:0] allele_offset;
        logic [15:0] qual_offset;
        logic [15:0] info_offset;
        logic [15:0] format_offset;
        logic [15:0] sample_offset;
        logic [15:0] field_count;
        logic        count_error;
    } vrt_tok_t;

endpackage

`default_nettype wire

// ===== src/vrt_channels.sv =====
`default_nettype none

// Byte stream channel carrying one record character per transaction.
interface vrt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Token channel carrying one result per transaction.
interface vrt_tok_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [15:0] pos_offset;
    logic [15:0] allele_offset;
    logic [15:0] qual_offset;
    logic [15:0] info_offset;
    logic [15:0] format_offset;
    logic [15:0] sample_offset;
    logic [15:0] field_count;
    logic        count_error;

    modport source (
        output valid, output out_byte, output out_last,
        output pos_offset, output allele_offset, output qual_offset,
        output info_offset, output format_offset, output sample_offset,
        output field_count, output count_error,
        input  ready
    );
    modport sink (
        input  valid, input out_byte, input out_last,
        input  pos_offset, input allele_offset, input qual_offset,
        input  info_offset, input format_offset, input sample_offset,
        input  field_count, input count_error,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/vrt_in_stage.sv =====
`default_nettype none

module vrt_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    vrt_byte_if.sink                record,
    input  wire logic               advance,
    output vrt_pkg::vrt_stage_t     stage
);
    import vrt_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    // The register takes a new transaction when empty or when it drains this cycle.
    assign record.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (record.ready)
        begin
            valid_next = record.valid;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge clk)
    begin
        if (record.valid && record.ready)
        begin
            byte_reg <= record.in_byte;
            last_reg <= record.in_last;
        end
    end

    assign stage.valid   = valid_reg;
    assign stage.in_byte = byte_reg;
    assign stage.in_last = last_reg;

endmodule

`default_nettype wire

// ===== src/vrt_core.sv =====
`default_nettype none

module vrt_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire vrt_pkg::vrt_stage_t stage,
    input  wire logic [13:0]        sample_count,
    output vrt_pkg::vrt_tok_t       result
);
    import vrt_pkg::*;

    logic [15:0] byte_position_reg, byte_position_next;
    logic [15:0] fields_seen_reg,   fields_seen_next;
    logic [15:0] pos_start_reg,     pos_start_next;
    logic [15:0] allele_start_reg,  allele_start_next;
    logic [15:0] qual_start_reg,    qual_start_next;
    logic [15:0] info_start_reg,    info_start_next;
    logic [15:0] format_start_reg,  format_start_next;
    logic [15:0] sample_start_reg,  sample_start_next;

    logic        have_samples;
    logic        tab_split;
    logic [15:0] offset;
    logic [15:0] k_inc;
    logic [15:0] upd_fields;
    logic [15:0] upd_pos;
    logic [15:0] upd_allele;
    logic [15:0] upd_qual;
    logic [15:0] upd_info;
    logic [15:0] upd_format;
    logic [15:0] upd_sample;
    logic [15:0] expected;
    logic        sep_zero;

    assign have_samples = (sample_count != 14'd0);
    assign tab_split    = (stage.in_byte == TAB_CH) &&
                          (have_samples || (fields_seen_reg < FIELDS_NO_SAMPLES));
    assign offset       = (byte_position_reg < POS_CEIL) ?
                          (byte_position_reg + 16'd1) : POS_CEIL;
    assign k_inc        = (fields_seen_reg != FIELD_MAX) ?
                          (fields_seen_reg + 16'd1) : fields_seen_reg;
    assign expected     = have_samples ? (FIELDS_FIXED + {2'b00, sample_count}) :
                          FIELDS_NO_SAMPLES;

    // Tab split: count the field and record the start offset of a tracked field.
    always_comb
    begin
        upd_fields = fields_seen_reg;
        upd_pos    = pos_start_reg;
        upd_allele = allele_start_reg;
        upd_qual   = qual_start_reg;
        upd_info   = info_start_reg;
        upd_format = format_start_reg;
        upd_sample = sample_start_reg;
        if (tab_split)
        begin
            upd_fields = k_inc;
            case (k_inc)
                FLD_POS:    upd_pos    = offset;
                FLD_REF:    upd_allele = offset;
                FLD_QUAL:   upd_qual   = offset;
                FLD_INFO:   upd_info   = offset;
                FLD_FORMAT:
                begin
                    if (have_samples)
                    begin
                        upd_format = offset;
                    end
                end
                FLD_SAMPLE:
                begin
                    if (have_samples)
                    begin
                        upd_sample = offset;
                    end
                end
                default:    upd_fields = k_inc;
            endcase
        end
    end

    // Split tabs, INFO semicolons (or late ones without samples), FORMAT colons.
    always_comb
    begin
        sep_zero = tab_split;
        if (stage.in_byte == SEMI_CH)
        begin
            sep_zero = (!have_samples && (fields_seen_reg >= FIELDS_NO_SAMPLES)) ||
                       (have_samples && (fields_seen_reg == FIELDS_NO_SAMPLES));
        end
        else if (stage.in_byte == COLON_CH)
        begin
            sep_zero = have_samples && (fields_seen_reg == FIELDS_FIXED);
        end
    end

    // Result item; the summary fields appear only on the final byte.
    always_comb
    begin
        result          = '0;
        result.out_byte = sep_zero ? 8'h00 : stage.in_byte;
        result.out_last = stage.in_last;
        if (stage.in_last)
        begin
            result.pos_offset    = upd_pos;
            result.allele_offset = upd_allele;
            result.qual_offset   = upd_qual;
            result.info_offset   = upd_info;
            result.format_offset = have_samples ? upd_format : 16'd0;
            result.sample_offset = have_samples ? upd_sample : 16'd0;
            result.field_count   = upd_fields;
            result.count_error   = (upd_fields != expected);
        end
    end

    // Record state rearms after the final byte.
    always_comb
    begin
        if (stage.in_last)
        begin
            byte_position_next = 16'd0;
            fields_seen_next   = 16'd1;
            pos_start_next     = 16'd0;
            allele_start_next  = 16'd0;
            qual_start_next    = 16'd0;
            info_start_next    = 16'd0;
            format_start_next  = 16'd0;
            sample_start_next  = 16'd0;
        end
        else
        begin
            byte_position_next = (byte_position_reg < POS_CEIL) ?
                                 (byte_position_reg + 16'd1) : byte_position_reg;
            fields_seen_next   = upd_fields;
            pos_start_next     = upd_pos;
            allele_start_next  = upd_allele;
            qual_start_next    = upd_qual;
            info_start_next    = upd_info;
            format_start_next  = upd_format;
            sample_start_next  = upd_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= 16'd0;
            fields_seen_reg   <= 16'd1;
            pos_start_reg     <= 16'd0;
            allele_start_reg  <= 16'd0;
            qual_start_reg    <= 16'd0;
            info_start_reg    <= 16'd0;
            format_start_reg  <= 16'd0;
            sample_start_reg  <= 16'd0;
        end
        else if (advance)
        begin
            byte_position_reg <= byte_position_next;
            fields_seen_reg   <= fields_seen_next;
            pos_start_reg     <= pos_start_next;
            allele_start_reg  <= allele_start_next;
            qual_start_reg    <= qual_start_next;
            info_start_reg    <= info_start_next;
            format_start_reg  <= format_start_next;
            sample_start_reg  <= sample_start_next;
        end
    end

`ifndef SYNTHESIS
    // A final byte rearms the record counters.
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        advance && stage.in_last |=> (fields_seen_reg == 16'd1) &&
                                      (byte_position_reg == 16'd0))
        else $error("record state not cleared after final byte");

    // The byte counter steps by one per non-final byte until it saturates.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !stage.in_last && (byte_position_reg != POS_CEIL)
        |=> byte_position_reg == $past(byte_position_reg) + 16'd1)
        else $error("byte position did not advance");

    // Record state changes only when a byte is processed.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(fields_seen_reg) && $stable(byte_position_reg))
        else $error("record state changed without a byte");

    // The field count never drops below one.
    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> fields_seen_reg != 16'd0)
        else $error("field count reached zero");
`endif

endmodule

`default_nettype wire

// ===== src/vrt_out_stage.sv =====
`default_nettype none

module vrt_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire vrt_pkg::vrt_tok_t  result,
    output logic                    can_load,
    vrt_tok_if.source               token
);
    import vrt_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    vrt_tok_t data_reg;

    // The result register is free when empty or when its transaction completes now.
    assign can_load = !valid_reg || token.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (token.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= result;
        end
    end

    assign token.valid         = valid_reg;
    assign token.out_byte      = data_reg.out_byte;
    assign token.out_last      = data_reg.out_last;
    assign token.pos_offset    = data_reg.pos_offset;
    assign token.allele_offset = data_reg.allele_offset;
    assign token.qual_offset   = data_reg.qual_offset;
    assign token.info_offset   = data_reg.info_offset;
    assign token.format_offset = data_reg.format_offset;
    assign token.sample_offset = data_reg.sample_offset;
    assign token.field_count   = data_reg.field_count;
    assign token.count_error   = data_reg.count_error;

endmodule

`default_nettype wire

// ===== src/vcf_record_tokenizer_top.sv =====
`default_nettype none

// VCF record tokenizer. Takes one record character per transaction on the record channel
// and returns one token transaction per character, with separators replaced by zero and
// the field offsets, field count and count error attached to the final byte. The block
// sustains one byte per clock cycle while the token channel is ready. A byte passes the
// input register, then the result register; the field counter and byte counter update
// with it, which sets that rate. Write sample_count only while no record is in flight.
module vcf_record_tokenizer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [13:0] cfg_wr_data,
    vrt_byte_if.sink         record,
    vrt_tok_if.source        token
);
    import vrt_pkg::*;

    logic [13:0] sample_count_reg;
    vrt_stage_t  stage;
    vrt_tok_t    result;
    logic        can_load;
    logic        advance;

    // Sample count configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= 14'd0;
        end
        else if (cfg_wr_en)
        begin
            sample_count_reg <= cfg_wr_data;
        end
    end

    // A byte moves into the result register when the register can take it.
    assign advance = stage.valid && can_load;

    vrt_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .record  (record),
        .advance (advance),
        .stage   (stage)
    );

    vrt_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .stage        (stage),
        .sample_count (sample_count_reg),
        .result       (result)
    );

    vrt_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .result   (result),
        .can_load (can_load),
        .token    (token)
    );

endmodule

`default_nettype wire

// ===== tb/sv/vcf_record_tokenizer_top_test.sv =====
`timescale 1ns / 1ps

module vcf_record_tokenizer_top_test;
    import vrt_pkg::*;

    // Characters used by the directed rows.
    localparam logic [7:0] CH_LETTER = 8'h41;
    localparam logic [7:0] CH_HIGH   = 8'hFF;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Cycles without any transaction before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_BYTES = 1800;

    typedef enum logic { ROW_BYTE, ROW_CFG } row_kind_t;

    // One row of the directed script: a byte or a sample_count write.
    // Rows with typed set carry their expected token in the t_* fields.
    typedef struct {
        row_kind_t   kind;
        logic [13:0] value;
        logic        lst;
        logic        typed;
        logic [7:0]  t_byte;
        logic [15:0] t_pos;
        logic [15:0] t_count;
        logic        t_err;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [13:0] cfg_wr_data;

    vrt_byte_if record_ch ();
    vrt_tok_if  token_ch ();

    vcf_record_tokenizer_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .record      (record_ch),
        .token       (token_ch)
    );

    // Tokenizer state mirrored by the predictor.
    logic [13:0] cur_samples;
    logic [15:0] at_byte;
    logic [15:0] field_num;
    logic [15:0] off_pos;
    logic [15:0] off_ref;
    logic [15:0] off_qual;
    logic [15:0] off_info;
    logic [15:0] off_fmt;
    logic [15:0] off_smp;

    vrt_tok_t   token_due[$];
    logic [7:0] line_q[$];
    row_t       script[30];

    logic send_idle;
    logic recv_idle;
    int   stall_left;
    int   quiet_cycles;
    int   mismatches;
    int   tokens_checked;
    int   records_seen;
    int   count_errors_seen;
    int   settings_used;
    int   random_bytes;

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Computes the token for one byte and advances the mirrored state.
    function automatic vrt_tok_t tokenize_byte(input logic [7:0] b, input logic lst);
        vrt_tok_t    t;
        logic        multi;
        logic [15:0] off;
        logic [15:0] want;
        multi = (cur_samples != 14'd0);
        t = '0;
        t.out_byte = b;
        t.out_last = lst;
        if (b == TAB_CH && (multi || field_num < FIELDS_NO_SAMPLES)) begin
            off = (at_byte < POS_CEIL) ? at_byte + 16'd1 : POS_CEIL;
            t.out_byte = 8'h00;
            if (field_num != FIELD_MAX)
                field_num = field_num + 16'd1;
            if (field_num == FLD_POS)
                off_pos = off;
            else if (field_num == FLD_REF)
                off_ref = off;
            else if (field_num == FLD_QUAL)
                off_qual = off;
            else if (field_num == FLD_INFO)
                off_info = off;
            else if (multi && field_num == FLD_FORMAT)
                off_fmt = off;
            else if (multi && field_num == FLD_SAMPLE)
                off_smp = off;
        end
        else if (b == SEMI_CH) begin
            if ((!multi && field_num >= FIELDS_NO_SAMPLES) ||
                (multi && field_num == FIELDS_NO_SAMPLES))
                t.out_byte = 8'h00;
        end
        else if (b == COLON_CH) begin
            if (multi && field_num == FIELDS_FIXED)
                t.out_byte = 8'h00;
        end

        if (lst) begin
            want = multi ? FIELDS_FIXED + {2'b00, cur_samples} : FIELDS_NO_SAMPLES;
            t.pos_offset    = off_pos;
            t.allele_offset = off_ref;
            t.qual_offset   = off_qual;
            t.info_offset   = off_info;
            t.format_offset = multi ? off_fmt : 16'd0;
            t.sample_offset = multi ? off_smp : 16'd0;
            t.field_count   = field_num;
            t.count_error   = (field_num != want);
            at_byte   = 16'd0;
            field_num = 16'd1;
            off_pos   = 16'd0;
            off_ref   = 16'd0;
            off_qual  = 16'd0;
            off_info  = 16'd0;
            off_fmt   = 16'd0;
            off_smp   = 16'd0;
        end
        else if (at_byte < POS_CEIL) begin
            at_byte = at_byte + 16'd1;
        end
        return t;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic row_t step_row(input row_kind_t kind, input logic [13:0] value,
                                      input logic lst);
        row_t r;
        r = '{kind, value, lst, 1'b0, 8'h00, 16'd0, 16'd0, 1'b0};
        return r;
    endfunction

    // Offers one byte, waits for the transaction and records its expected token.
    task automatic push_byte(input logic [7:0] b, input logic lst, input logic typed,
                             input vrt_tok_t fixed);
        int       gap;
        vrt_tok_t pred;
        if (send_idle && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            @(negedge clk);
            record_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        record_ch.valid   = 1'b1;
        record_ch.in_byte = b;
        record_ch.in_last = lst;
        do
            @(posedge clk);
        while (!record_ch.ready);
        pred = tokenize_byte(b, lst);
        token_due = {token_due, (typed ? fixed : pred)};
    endtask

    // Writes sample_count once the block has drained.
    task automatic set_sample_count(input logic [13:0] v);
        @(negedge clk);
        record_ch.valid = 1'b0;
        while (token_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        cur_samples = v;
        settings_used++;
    endtask

    // Builds one record for the given sample count: some plain noise; for counts
    // up to six mostly well-formed records with random field contents, some with
    // wrong field counts, some cut short; for larger counts 1 to 12 fields.
    task automatic compose_record(input logic [13:0] sc);
        int nf;
        int r;
        line_q.delete();
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 24))
                line_q = {line_q, (($urandom_range(0, 4) < 2) ? TAB_CH :
                                   8'($urandom_range(0, 255)))};
        end
        else begin
            if (sc > 14'd6) begin
                nf = $urandom_range(1, 12);
            end
            else begin
                nf = (sc == 14'd0) ? 8 : 9 + int'(sc);
                r = $urandom_range(0, 9);
                if (r < 2)
                    nf = nf + int'($urandom_range(0, 4)) - 2;
                else if (r == 2)
                    nf = $urandom_range(1, nf);
            end
            if (nf < 1)
                nf = 1;
            for (int f = 0; f < nf; f++) begin
                if (f > 0)
                    line_q = {line_q, TAB_CH};
                repeat ($urandom_range(0, 5)) begin
                    r = $urandom_range(0, 9);
                    case (r)
                        0:       line_q = {line_q, SEMI_CH};
                        1:       line_q = {line_q, COLON_CH};
                        2:       line_q = {line_q, 8'($urandom_range(0, 255))};
                        default: line_q = {line_q, 8'($urandom_range(33, 126))};
                    endcase
                end
            end
            if (line_q.size() == 0)
                line_q = {line_q, CH_LETTER};
        end
    endtask

    // Token sink: random stalls while idling is enabled.
    initial begin
        token_ch.ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (!rst_n) begin
                token_ch.ready = 1'b0;
            end
            else if (stall_left > 0) begin
                token_ch.ready = 1'b0;
                stall_left--;
            end
            else if (recv_idle && $urandom_range(0, 4) == 0) begin
                token_ch.ready = 1'b0;
                stall_left = pick_gap() - 1;
            end
            else begin
                token_ch.ready = 1'b1;
            end
        end
    end

    task automatic note_field(input string fname, input logic [15:0] want,
                              input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("token %0d: %s expected %0h, got %0h",
                         tokens_checked, fname, want, got);
        end
    endtask

    // Compare each token transaction with the oldest expectation.
    always @(posedge clk) begin : check_token
        vrt_tok_t got;
        vrt_tok_t want;
        if (rst_n && token_ch.valid && token_ch.ready) begin
            got.out_byte      = token_ch.out_byte;
            got.out_last      = token_ch.out_last;
            got.pos_offset    = token_ch.pos_offset;
            got.allele_offset = token_ch.allele_offset;
            got.qual_offset   = token_ch.qual_offset;
            got.info_offset   = token_ch.info_offset;
            got.format_offset = token_ch.format_offset;
            got.sample_offset = token_ch.sample_offset;
            got.field_count   = token_ch.field_count;
            got.count_error   = token_ch.count_error;
            if (token_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("token %0d arrived with nothing expected: byte %0h",
                             tokens_checked, got.out_byte);
            end
            else begin
                want = token_due.pop_front();
                note_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
                note_field("out_last", 16'(want.out_last), 16'(got.out_last));
                note_field("pos_offset", want.pos_offset, got.pos_offset);
                note_field("allele_offset", want.allele_offset, got.allele_offset);
                note_field("qual_offset", want.qual_offset, got.qual_offset);
                note_field("info_offset", want.info_offset, got.info_offset);
                note_field("format_offset", want.format_offset, got.format_offset);
                note_field("sample_offset", want.sample_offset, got.sample_offset);
                note_field("field_count", want.field_count, got.field_count);
                note_field("count_error", 16'(want.count_error), 16'(got.count_error));
            end
            if (got.out_last === 1'b1) begin
                records_seen++;
                if (got.count_error === 1'b1)
                    count_errors_seen++;
            end
            tokens_checked++;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk) begin
        if (!rst_n || (record_ch.valid && record_ch.ready) ||
            (token_ch.valid && token_ch.ready)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Stimulus: directed script, then random records.
    initial begin
        vrt_tok_t    fixed;
        logic [13:0] sc;
        int          phase;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = 14'd0;
        record_ch.valid   = 1'b0;
        record_ch.in_byte = 8'h00;
        record_ch.in_last = 1'b0;
        send_idle         = 1'b1;
        recv_idle         = 1'b1;
        settings_used     = 0;
        random_bytes      = 0;
        cur_samples       = 14'd0;
        at_byte           = 16'd0;
        field_num         = 16'd1;
        off_pos           = 16'd0;
        off_ref           = 16'd0;
        off_qual          = 16'd0;
        off_info          = 16'd0;
        off_fmt           = 16'd0;
        off_smp           = 16'd0;

        script = '{
            // Reset value of sample_count is zero: eight fields expected.
            // A one-byte record ends early.
            '{ROW_BYTE, 14'(CH_LETTER), 1'b1, 1'b1, CH_LETTER, 16'd0, 16'd1, 1'b1},
            // Not the last byte: everything but the byte itself is zero.
            '{ROW_BYTE, 14'(CH_HIGH), 1'b0, 1'b1, CH_HIGH, 16'd0, 16'd0, 1'b0},
            // A zero byte is an ordinary character.
            '{ROW_BYTE, 14'(CH_NUL), 1'b1, 1'b1, CH_NUL, 16'd0, 16'd1, 1'b1},
            // A lone tab opens POS at offset one.
            '{ROW_BYTE, 14'(TAB_CH), 1'b1, 1'b1, 8'h00, 16'd1, 16'd2, 1'b1},
            // One sample: separators in INFO and FORMAT, exact field count.
            step_row(ROW_CFG, 14'd1, 1'b0),
            step_row(ROW_BYTE, 14'(TAB_CH), 1'b0),
            step_row(ROW_BYTE, 14'(TAB_CH), 1'b0),
            step_row(ROW_BYTE, 14'(TAB_CH), 1'b0),
            step_row(ROW_BYTE, 14'(TAB_CH), 1'b0),
            step_row(ROW_BYTE, 14'(TAB_CH), 1'b0),
            step_row(ROW_BYTE, 14'(TAB_CH), 1'b0),
            step_row(ROW_BYTE, 14'(TAB_CH), 1'b0),
            step_row(ROW_BYTE, 14'(SEMI_CH), 1'b0),
            step_row(ROW_BYTE, 14'(TAB_CH), 1'b0),
            step_row(ROW_BYTE, 14'(COLON_CH), 1'b0),
            step_row(ROW_BYTE, 14'(TAB_CH), 1'b0),
            step_row(ROW_BYTE, 14'(COLON_CH), 1'b1),
            // Largest sample count, then a write in the middle of a record.
            step_row(ROW_CFG, 14'h3FFF, 1'b0),
            step_row(ROW_BYTE, 14'(TAB_CH), 1'b0),
            step_row(ROW_CFG, 14'd0, 1'b0),
            step_row(ROW_BYTE, 14'(SEMI_CH), 1'b1),
            // No samples: the eighth tab passes through, the semicolon is cut.
            step_row(ROW_BYTE, 14'(TAB_CH), 1'b0),
            step_row(ROW_BYTE, 14'(TAB_CH), 1'b0),
            step_row(ROW_BYTE, 14'(TAB_CH), 1'b0),
            step_row(ROW_BYTE, 14'(TAB_CH), 1'b0),
            step_row(ROW_BYTE, 14'(TAB_CH), 1'b0),
            step_row(ROW_BYTE, 14'(TAB_CH), 1'b0),
            step_row(ROW_BYTE, 14'(TAB_CH), 1'b0),
            step_row(ROW_BYTE, 14'(TAB_CH), 1'b0),
            step_row(ROW_BYTE, 14'(SEMI_CH), 1'b1)
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed script.
        for (int i = 0; i < $size(script); i++) begin
            if (script[i].kind == ROW_CFG) begin
                set_sample_count(script[i].value);
            end
            else begin
                fixed = '0;
                fixed.out_byte    = script[i].t_byte;
                fixed.out_last    = script[i].lst;
                fixed.pos_offset  = script[i].t_pos;
                fixed.field_count = script[i].t_count;
                fixed.count_error = script[i].t_err;
                push_byte(script[i].value[7:0], script[i].lst, script[i].typed, fixed);
            end
        end

        // Random records over a rotation of sample count settings.
        phase = 0;
        while (random_bytes < RANDOM_BYTES) begin
            case (phase % 6)
                0:       sc = 14'd0;
                1:       sc = 14'd1;
                2:       sc = 14'($urandom_range(2, 6));
                3:       sc = 14'h3FFF;
                4:       sc = 14'($urandom_range(0, 16383));
                default: sc = 14'($urandom_range(1, 3));
            endcase
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            set_sample_count(sc);
            repeat ($urandom_range(3, 8)) begin
                compose_record(sc);
                for (int i = 0; i < line_q.size(); i++)
                    push_byte(line_q[i], i == line_q.size() - 1, 1'b0, '0);
                random_bytes += line_q.size();
            end
            phase++;
        end

        // Drain and finish.
        @(negedge clk);
        record_ch.valid = 1'b0;
        while (token_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Checked %0d tokens in %0d records, %0d of them with a field count error.",
                 tokens_checked, records_seen, count_errors_seen);
        $display("Applied %0d sample count settings from 0 to 16383, %0d mismatches found.",
                 settings_used, mismatches);
        if (mismatches == 0 && token_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
